// ----- rtl/cbia_pkg.sv -----
// Package for the chunked block index allocator.
// Holds widths, sizes, status and command codes and the item and result types.
// No dependencies.
package cbia_pkg;

    localparam int NUM_CHUNKS       = 16;
    localparam int BLOCKS_PER_CHUNK = 255;

    localparam int CHUNK_W  = 4;
    localparam int BLOCK_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int ACTIVE_W = $clog2(NUM_CHUNKS + 1);
    localparam int BSIZE_W  = 9;
    localparam int OFFSET_W = 20;
    localparam int INDEX_W  = 12;

    localparam int LINK_AW    = CHUNK_W + BLOCK_W;
    localparam int LINK_DEPTH = NUM_CHUNKS * (2 ** BLOCK_W);

    localparam int QUEUE_DEPTH = 2;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 9'd64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } cbia_status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cbia_cmd_t;

    typedef struct packed {
        cbia_cmd_t            cmd;
        logic                 chunk_oob;
        logic                 block_oob;
        logic [CHUNK_W-1:0]   chunk;
        logic [BLOCK_W-1:0]   block;
    } cbia_item_t;

    typedef struct packed {
        cbia_status_t         status;
        logic [CHUNK_W-1:0]   chunk;
        logic [BLOCK_W-1:0]   block;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   free_left;
    } cbia_result_t;

endpackage

// ----- rtl/chunked_block_index_allocator.sv -----
// Top level of the chunked block index allocator: block size register,
// front queue and back end. Depends on cbia_pkg, cbia_front, cbia_back.
//
//   channel   prefix   carries                                        handshake
//   request   s_       cmd, free_chunk, free_block                    valid/ready
//   result    m_       status, out_chunk, out_block, byte_offset,     valid/ready
//                      chunk_free_left
//   config    cfg_     block size in bytes                            write enable
//
// An allocate goes through the back end in steps (choose chunk, read head, pop link
// and multiply for the offset, load result register); a free skips the head read and link pop.
// The link memory has one read and one write port.
// After reset the link memory is initialized, one entry a cycle, over all 4096 entries;
// s_ready stays low meanwhile. A stalled result holds the back end in its last
// step while the front queue keeps taking up to two requests.
module chunked_block_index_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cbia_pkg::BSIZE_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [cbia_pkg::CHUNK_W-1:0]  s_free_chunk,
    input  logic [cbia_pkg::BLOCK_W-1:0]  s_free_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [cbia_pkg::CHUNK_W-1:0]  m_out_chunk,
    output logic [cbia_pkg::BLOCK_W-1:0]  m_out_block,
    output logic [cbia_pkg::OFFSET_W-1:0] m_byte_offset,
    output logic [cbia_pkg::COUNT_W-1:0]  m_chunk_free_left
);
    import cbia_pkg::*;

    logic [BSIZE_W-1:0] bsize_reg;
    logic               init_done;
    logic               q_valid;
    logic               q_ready;
    cbia_item_t         q_item;
    cbia_result_t       result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsize_reg <= BSIZE_RESET;
        end else if (cfg_wr_en) begin
            bsize_reg <= cfg_wr_data;
        end
    end

    cbia_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_en    (init_done),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_free_chunk (s_free_chunk),
        .s_free_block (s_free_block),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    cbia_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .blk_bytes  (bsize_reg),
        .init_done  (init_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    assign m_status          = result.status;
    assign m_out_chunk       = result.chunk;
    assign m_out_block       = result.block;
    assign m_byte_offset     = result.offset;
    assign m_chunk_free_left = result.free_left;

`ifndef ASSERT_OFF
    a_init_stays_done: assert property (@(posedge aclk) disable iff (!aresetn)
        init_done |=> init_done)
        else $error("link memory init restarted");

    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid)
        else $error("accepted request missing from queue");

    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_EXHAUSTED)) |->
            ((m_byte_offset == '0) && (m_chunk_free_left == '0) && (m_out_chunk == '0)))
        else $error("exhausted result carries nonzero fields");
`endif

endmodule

// ----- rtl/cbia_front.sv -----
// Front end of the allocator: accepts request transfers, classifies them
// and queues them for the back end. Depends on cbia_pkg.
module cbia_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept_en,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [cbia_pkg::CHUNK_W-1:0] s_free_chunk,
    input  logic [cbia_pkg::BLOCK_W-1:0] s_free_block,
    output logic                         q_valid,
    input  logic                         q_ready,
    output cbia_pkg::cbia_item_t         q_item
);
    import cbia_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cbia_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    cbia_item_t         in_item;
    logic               push;
    logic               pop;

    always_comb begin
        in_item.cmd       = cbia_cmd_t'(s_cmd);
        in_item.chunk_oob = (32'(s_free_chunk) >= NUM_CHUNKS);
        in_item.block_oob = (32'(s_free_block) >= BLOCKS_PER_CHUNK);
        in_item.chunk     = s_free_chunk;
        in_item.block     = s_free_block;
    end

    assign s_ready = accept_en && (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/cbia_back.sv -----
// Back end of the allocator: chunk search, free lists, link memory and
// the result register. Depends on cbia_pkg.
module cbia_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  cbia_pkg::cbia_item_t         q_item,
    input  logic [cbia_pkg::BSIZE_W-1:0] blk_bytes,
    output logic                         init_done,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cbia_pkg::cbia_result_t       m_result
);
    import cbia_pkg::*;

    typedef enum logic [2:0] {
        B_INIT,
        B_EXEC,
        B_READ,
        B_POP,
        B_DONE
    } back_state_t;

    localparam logic [INDEX_W-1:0] BPC_IDX   = INDEX_W'(BLOCKS_PER_CHUNK);
    localparam logic [COUNT_W-1:0] BPC_COUNT = COUNT_W'(BLOCKS_PER_CHUNK);
    localparam logic [LINK_AW-1:0] LINK_LAST = LINK_AW'(LINK_DEPTH - 1);

    back_state_t               state_reg;
    logic [LINK_AW-1:0]        sweep_reg;
    logic [ACTIVE_W-1:0]       active_reg;
    logic [CHUNK_W-1:0]        last_reg;
    logic [CHUNK_W-1:0]        sel_reg;
    logic [BLOCK_W-1:0]        head_reg  [NUM_CHUNKS];
    logic [COUNT_W-1:0]        count_reg [NUM_CHUNKS];
    logic [BLOCK_W-1:0]        blk_reg;
    logic [INDEX_W-1:0]        idx_reg;
    cbia_result_t              pend_reg;
    logic                      m_valid_reg;
    cbia_result_t              m_result_reg;

    logic [BLOCK_W-1:0]        link_mem [LINK_DEPTH];
    logic [BLOCK_W-1:0]        link_rdata_reg;

    logic [CHUNK_W-1:0]        acc_chunk;
    logic [BLOCK_W-1:0]        head_rd;
    logic [COUNT_W-1:0]        count_rd;
    logic [NUM_CHUNKS-1:0]     nz;
    logic                      found_any;
    logic [CHUNK_W-1:0]        first_chunk;
    logic                      is_free;
    logic                      free_ok;
    logic                      link_we;
    logic [LINK_AW-1:0]        link_waddr;
    logic [BLOCK_W-1:0]        link_wdata;
    logic [LINK_AW-1:0]        link_raddr;
    logic [INDEX_W+BSIZE_W-1:0] prod;

    always_comb begin
        acc_chunk = sel_reg;
        if (state_reg == B_EXEC) begin
            acc_chunk = (q_item.cmd == CMD_FREE) ? q_item.chunk : last_reg;
        end
    end

    assign head_rd  = head_reg[acc_chunk];
    assign count_rd = count_reg[acc_chunk];

    always_comb begin
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            nz[i] = (ACTIVE_W'(i) < active_reg) && (count_reg[i] != '0);
        end
    end

    always_comb begin
        first_chunk = '0;
        for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
            if (nz[i]) begin
                first_chunk = CHUNK_W'(i);
            end
        end
    end

    assign found_any = |nz;
    assign is_free   = (q_item.cmd == CMD_FREE);
    assign free_ok   = !q_item.chunk_oob && !q_item.block_oob
                       && ({1'b0, q_item.chunk} < active_reg)
                       && (count_rd < BPC_COUNT);

    assign q_ready   = (state_reg == B_EXEC);
    assign init_done = (state_reg != B_INIT);

    assign link_we    = (state_reg == B_INIT)
                        || ((state_reg == B_EXEC) && q_valid && is_free && free_ok);
    assign link_waddr = (state_reg == B_INIT) ? sweep_reg : {q_item.chunk, q_item.block};
    assign link_wdata = (state_reg == B_INIT) ? sweep_reg[BLOCK_W-1:0] + 1'b1 : head_rd;
    assign link_raddr = {sel_reg, head_rd};

    assign prod = {{BSIZE_W{1'b0}}, idx_reg} * {{INDEX_W{1'b0}}, blk_bytes};

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_INIT;
            sweep_reg   <= '0;
            active_reg  <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHUNKS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != B_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_INIT: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == LINK_LAST) begin
                        state_reg <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    if (q_valid) begin
                        if (is_free) begin
                            pend_reg.chunk  <= q_item.chunk;
                            pend_reg.block  <= q_item.block;
                            pend_reg.offset <= '0;
                            if (free_ok) begin
                                head_reg[q_item.chunk]  <= q_item.block;
                                count_reg[q_item.chunk] <= count_rd + 1'b1;
                                pend_reg.status         <= ST_OK;
                                pend_reg.free_left      <= count_rd + 1'b1;
                            end else begin
                                pend_reg.status    <= ST_INVALID;
                                pend_reg.free_left <= q_item.chunk_oob ? '0 : count_rd;
                            end
                            state_reg <= B_DONE;
                        end else if (nz[last_reg]) begin
                            sel_reg   <= last_reg;
                            state_reg <= B_READ;
                        end else if (found_any) begin
                            sel_reg   <= first_chunk;
                            state_reg <= B_READ;
                        end else if (active_reg < ACTIVE_W'(NUM_CHUNKS)) begin
                            sel_reg                              <= active_reg[CHUNK_W-1:0];
                            head_reg[active_reg[CHUNK_W-1:0]]  <= '0;
                            count_reg[active_reg[CHUNK_W-1:0]] <= BPC_COUNT;
                            active_reg                           <= active_reg + 1'b1;
                            state_reg                            <= B_READ;
                        end else begin
                            pend_reg.status    <= ST_EXHAUSTED;
                            pend_reg.chunk     <= '0;
                            pend_reg.block     <= '0;
                            pend_reg.offset    <= '0;
                            pend_reg.free_left <= '0;
                            state_reg          <= B_DONE;
                        end
                    end
                end
                B_READ: begin
                    blk_reg   <= head_rd;
                    idx_reg   <= INDEX_W'(sel_reg) * BPC_IDX + INDEX_W'(head_rd);
                    state_reg <= B_POP;
                end
                B_POP: begin
                    head_reg[sel_reg]  <= link_rdata_reg;
                    count_reg[sel_reg] <= count_rd - 1'b1;
                    last_reg           <= sel_reg;
                    pend_reg.status    <= ST_OK;
                    pend_reg.chunk     <= sel_reg;
                    pend_reg.block     <= blk_reg;
                    pend_reg.offset    <= prod[OFFSET_W-1:0];
                    pend_reg.free_left <= count_rd - 1'b1;
                    state_reg          <= B_DONE;
                end
                B_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_result_reg <= pend_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= B_EXEC;
                    end
                end
                default: begin
                    state_reg <= B_INIT;
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for chunked_block_index_allocator: random-gap request and result
// traffic, a scoreboard class that predicts every grant, field-by-field checks.
// Depends on cbia_pkg and the allocator RTL.

class grant_scoreboard;
    logic [7:0]             link_next [cbia_pkg::NUM_CHUNKS][256];
    logic [7:0]             chunk_head [cbia_pkg::NUM_CHUNKS];
    int unsigned            chunk_free [cbia_pkg::NUM_CHUNKS];
    int unsigned            chunks_live;
    int unsigned            recent_chunk;
    logic [8:0]             bytes_per_block;
    cbia_pkg::cbia_result_t due_grants [$];
    logic [11:0]            held_blocks [$];
    int                     errors;

    function new();
        for (int c = 0; c < cbia_pkg::NUM_CHUNKS; c++) begin
            chunk_head[c] = '0;
            chunk_free[c] = 0;
            for (int i = 0; i < 256; i++) link_next[c][i] = '0;
        end
        chunks_live     = 0;
        recent_chunk    = 0;
        bytes_per_block = cbia_pkg::BSIZE_RESET;
        errors          = 0;
    endfunction

    function void open_chunk(int c);
        chunk_head[c] = '0;
        chunk_free[c] = cbia_pkg::BLOCKS_PER_CHUNK;
        for (int i = 0; i < cbia_pkg::BLOCKS_PER_CHUNK; i++) link_next[c][i] = 8'(i + 1);
    endfunction

    function void take_request(cbia_pkg::cbia_cmd_t cmd, logic [3:0] fc, logic [7:0] fb);
        cbia_pkg::cbia_result_t want;
        int                     c;
        bit                     hit;
        logic [7:0]             b;
        logic [31:0]            span;
        int                     hits [$];
        want = '0;
        if (cmd == cbia_pkg::CMD_ALLOC) begin
            if (chunks_live == 0) begin
                open_chunk(0);
                chunks_live = 1;
            end
            hit = 0;
            c   = 0;
            if (recent_chunk < chunks_live && chunk_free[recent_chunk] != 0) begin
                c   = recent_chunk;
                hit = 1;
            end else begin
                for (int i = 0; i < chunks_live; i++) begin
                    if (!hit && chunk_free[i] != 0) begin
                        c   = i;
                        hit = 1;
                    end
                end
            end
            if (!hit) begin
                if (chunks_live >= cbia_pkg::NUM_CHUNKS) begin
                    want.status = cbia_pkg::ST_EXHAUSTED;
                    due_grants  = {due_grants, want};
                    return;
                end
                c = chunks_live;
                open_chunk(c);
                chunks_live++;
            end
            recent_chunk  = c;
            b             = chunk_head[c];
            chunk_head[c] = link_next[c][b];
            chunk_free[c]--;
            span           = (c * cbia_pkg::BLOCKS_PER_CHUNK + b) * bytes_per_block;
            want.status    = cbia_pkg::ST_OK;
            want.chunk     = 4'(c);
            want.block     = b;
            want.offset    = span[19:0];
            want.free_left = 8'(chunk_free[c]);
            held_blocks    = {held_blocks, {4'(c), b}};
        end else begin
            want.chunk = fc;
            want.block = fb;
            if (fc >= chunks_live || fb >= cbia_pkg::BLOCKS_PER_CHUNK ||
                chunk_free[fc] >= cbia_pkg::BLOCKS_PER_CHUNK) begin
                want.status = cbia_pkg::ST_INVALID;
            end else begin
                link_next[fc][fb] = chunk_head[fc];
                chunk_head[fc]    = fb;
                chunk_free[fc]++;
                want.status = cbia_pkg::ST_OK;
                hits = held_blocks.find_first_index(h) with (h == {fc, fb});
                if (hits.size() != 0) held_blocks.delete(hits[0]);
            end
            want.free_left = 8'(chunk_free[fc]);
        end
        due_grants = {due_grants, want};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_grant(cbia_pkg::cbia_result_t got);
        cbia_pkg::cbia_result_t want;
        if (due_grants.size() == 0) begin
            $error("result transfer with nothing outstanding: status %0d chunk %0d block %0d",
                   got.status, got.chunk, got.block);
            errors++;
            return;
        end
        want = due_grants.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("out_chunk", want.chunk, got.chunk);
        compare_field("out_block", want.block, got.block);
        compare_field("byte_offset", want.offset, got.offset);
        compare_field("chunk_free_left", want.free_left, got.free_left);
    endfunction
endclass

module tb_top;
    import cbia_pkg::*;

    localparam int STALL_LIMIT = 12000;

    logic                aclk;
    logic                aresetn           = 1'b0;
    logic                cfg_wr_en         = 1'b0;
    logic [BSIZE_W-1:0]  cfg_wr_data       = '0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic                s_cmd             = 1'b0;
    logic [CHUNK_W-1:0]  s_free_chunk      = '0;
    logic [BLOCK_W-1:0]  s_free_block      = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [1:0]          m_status;
    logic [CHUNK_W-1:0]  m_out_chunk;
    logic [BLOCK_W-1:0]  m_out_block;
    logic [OFFSET_W-1:0] m_byte_offset;
    logic [COUNT_W-1:0]  m_chunk_free_left;

    grant_scoreboard sb;
    cbia_result_t    seen;
    bit              quiet;
    bit              have_freed;
    logic [11:0]     last_freed;

    chunked_block_index_allocator u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_free_chunk      (s_free_chunk),
        .s_free_block      (s_free_block),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_chunk       (m_out_chunk),
        .m_out_block       (m_out_block),
        .m_byte_offset     (m_byte_offset),
        .m_chunk_free_left (m_chunk_free_left)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.status    = cbia_status_t'(m_status);
                seen.chunk     = m_out_chunk;
                seen.block     = m_out_block;
                seen.offset    = m_byte_offset;
                seen.free_left = m_chunk_free_left;
                sb.check_grant(seen);
            end
            if (s_valid && s_ready)
                sb.take_request(cbia_cmd_t'(s_cmd), s_free_chunk, s_free_block);
        end
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_run = 0;
            else idle_run++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic issue_req(input cbia_cmd_t cmd, input logic [3:0] fc, input logic [7:0] fb);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_free_chunk <= fc;
        s_free_block <= fb;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic alloc_one();
        issue_req(CMD_ALLOC, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic free_held();
        int          idx;
        logic [11:0] key;
        if (sb.held_blocks.size() == 0) begin
            alloc_one();
            return;
        end
        idx = $urandom_range(0, sb.held_blocks.size() - 1);
        key = sb.held_blocks[idx];
        sb.held_blocks.delete(idx);
        last_freed = key;
        have_freed = 1'b1;
        issue_req(CMD_FREE, key[11:8], key[7:0]);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_grants.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_blk_bytes(input logic [BSIZE_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en          <= 1'b0;
        sb.bytes_per_block = value;
        quiet              = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_mix(input int count, input int alloc_pct, input bit allow_dup);
        int         pick;
        logic [3:0] fc;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct || (pick < 90 && sb.held_blocks.size() == 0)) begin
                alloc_one();
            end else if (pick < 90) begin
                free_held();
            end else if (pick >= 97 && allow_dup && have_freed) begin
                issue_req(CMD_FREE, last_freed[11:8], last_freed[7:0]);
            end else if (sb.chunks_live + 1 < NUM_CHUNKS && $urandom_range(0, 1) == 1) begin
                // stay clear of a chunk that may be opening right now
                fc = 4'($urandom_range(sb.chunks_live + 1, NUM_CHUNKS - 1));
                issue_req(CMD_FREE, fc, 8'($urandom_range(0, 255)));
            end else begin
                issue_req(CMD_FREE, 4'($urandom_range(0, 15)), 8'hFF);
            end
        end
    endtask

    initial begin
        sb         = new();
        quiet      = 1'b0;
        have_freed = 1'b0;
        last_freed = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue_req(CMD_ALLOC, 4'hF, 8'hFF);
        issue_req(CMD_FREE, 4'hF, 8'd254);
        issue_req(CMD_FREE, 4'h0, 8'hFF);
        alloc_one();
        issue_req(CMD_FREE, 4'h0, 8'h00);
        issue_req(CMD_FREE, 4'h0, 8'h01);
        issue_req(CMD_FREE, 4'h0, 8'h01);
        issue_req(CMD_FREE, 4'h0, 8'd254);
        repeat (3) alloc_one();
        issue_req(CMD_FREE, 4'h1, 8'h00);
        free_held();
        free_held();

        set_blk_bytes(9'd1);
        run_mix(200, 60, 1'b0);
        set_blk_bytes(9'd256);
        run_mix(240, 80, 1'b0);
        set_blk_bytes(9'd511);
        run_mix(200, 35, 1'b0);
        set_blk_bytes(9'($urandom_range(1, 256)));
        run_mix(200, 60, 1'b1);

        // long allocate run, then release and reuse
        set_blk_bytes(9'($urandom_range(1, 256)));
        repeat (100) alloc_one();
        repeat (40) free_held();
        repeat (45) alloc_one();

        // free one block twice and hand it out again
        settle();
        free_held();
        issue_req(CMD_FREE, last_freed[11:8], last_freed[7:0]);
        repeat (3) alloc_one();

        settle();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
